[design/aopt_pkg.sv]
// aopt_pkg: shared types and codes for the age ordered peer table
// no dependencies
package aopt_pkg;
   localparam int OP_BITS     = 3;
   localparam int AGE_BITS    = 32;
   localparam int STEP_BITS   = 16;
   localparam int STATUS_BITS = 2;
   localparam int CNT_BITS    = 6;
   localparam int CFG_BITS    = 32;
   localparam int IDX_BITS    = 1;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_ADD    = 3'd1,
      OP_DELETE = 3'd2,
      OP_AGE    = 3'd3,
      OP_LOOKUP = 3'd4
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE    = 2'd0,
      ST_PRESENT = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   localparam logic [IDX_BITS-1:0] REG_CAPACITY  = 1'b0;
   localparam logic [IDX_BITS-1:0] REG_AGE_LIMIT = 1'b1;

   // command from controller to datapath
   typedef struct packed {
      logic load;
      logic apply;
   } cmd_type;
endpackage

[design/aopt_req_if.sv]
// aopt_req_if, aopt_rsp_if: valid/ready channels of the peer table
// uses aopt_pkg
interface aopt_req_if #(parameter int KEY_BITS = 48, parameter int META_BITS = 32);
   import aopt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_BITS-1:0]   op;
   logic [KEY_BITS-1:0]  node_key;
   logic [AGE_BITS-1:0]  entry_age;
   logic [META_BITS-1:0] meta_in;
   logic [STEP_BITS-1:0] age_step;
   modport source (output valid, op, node_key, entry_age, meta_in, age_step, input ready);
   modport sink   (input valid, op, node_key, entry_age, meta_in, age_step, output ready);
endinterface

interface aopt_rsp_if #(parameter int META_BITS = 32);
   import aopt_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [CNT_BITS-1:0]    position;
   logic [CNT_BITS-1:0]    entry_count;
   logic [AGE_BITS-1:0]    found_age;
   logic [META_BITS-1:0]   found_meta;
   modport source (output valid, status, position, entry_count, found_age, found_meta,
                   input ready);
   modport sink   (input valid, status, position, entry_count, found_age, found_meta,
                   output ready);
endinterface

[design/aopt_ctrl.sv]
// aopt_ctrl: handshake controller, load then apply then present the beat
// uses aopt_pkg
module aopt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output aopt_pkg::cmd_type cmd
);
   import aopt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WORK, S_OUT} state_type;
   state_type state_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign cmd.load  = req_valid && req_ready;
   assign cmd.apply = (state_ff == S_WORK);

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_WORK;
            S_WORK: state_ff <= S_OUT;
            S_OUT:  if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> !req_ready) else $error("accept while busy");
   a_work_one: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid) else $error("work did not finish");
endmodule

[design/aopt_dp.sv]
// aopt_dp: per-entry compare and shift cells of the peer table
// uses aopt_pkg
module aopt_dp #(
   parameter int DEPTH     = 32,
   parameter int KEY_BITS  = 48,
   parameter int META_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  aopt_pkg::cmd_type             cmd,
   input  logic [aopt_pkg::OP_BITS-1:0]  op,
   input  logic [KEY_BITS-1:0]           node_key,
   input  logic [aopt_pkg::AGE_BITS-1:0] entry_age,
   input  logic [META_BITS-1:0]          meta_in,
   input  logic [aopt_pkg::STEP_BITS-1:0] age_step,
   input  logic [aopt_pkg::CNT_BITS-1:0] capacity,
   input  logic [aopt_pkg::AGE_BITS-1:0] age_limit,
   output logic [aopt_pkg::STATUS_BITS-1:0] status,
   output logic [aopt_pkg::CNT_BITS-1:0] position,
   output logic [aopt_pkg::CNT_BITS-1:0] entry_count,
   output logic [aopt_pkg::AGE_BITS-1:0] found_age,
   output logic [META_BITS-1:0]          found_meta
);
   import aopt_pkg::*;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = $clog2(DEPTH);

   logic [KEY_BITS-1:0]  key_ff [DEPTH];
   logic [AGE_BITS-1:0]  age_ff [DEPTH];
   logic [META_BITS-1:0] meta_ff [DEPTH];
   logic [CW-1:0]        count_ff;

   // captured request and per-slot compare flags
   logic [OP_BITS-1:0]   op_ff;
   logic [KEY_BITS-1:0]  rkey_ff;
   logic [AGE_BITS-1:0]  rage_ff;
   logic [META_BITS-1:0] rmeta_ff;
   logic [STEP_BITS-1:0] rstep_ff;
   logic [DEPTH-1:0]     hit_ff, le_ff, exp_ff, live_ff;

   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [CNT_BITS-1:0]    pos_ff, pos_in;
   logic [AGE_BITS-1:0]    fage_ff, fage_in;
   logic [META_BITS-1:0]   fmeta_ff, fmeta_in;

   // stage one: compare every live slot against the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op; rkey_ff <= node_key; rage_ff <= entry_age;
         rmeta_ff <= meta_in; rstep_ff <= age_step;
         for (int i = 0; i < DEPTH; i++) begin
            live_ff[i] <= (CW'(i) < count_ff);
            hit_ff[i]  <= (CW'(i) < count_ff) && (key_ff[i] == node_key);
            le_ff[i]   <= age_ff[i] <= entry_age;
            exp_ff[i]  <= (age_limit != '0) &&
                          ({1'b0, age_ff[i]} + (AGE_BITS+1)'(age_step) >
                           {1'b0, age_limit});
         end
      end
   end

   // stage two decode
   logic           any_hit, full;
   logic [SW-1:0]  hit_idx;
   logic [CW-1:0]  ins_pos, cut, eff_cap;
   logic [DEPTH-1:0] first_hit;
   always_comb begin
      eff_cap = (CNT_BITS'(DEPTH) < capacity) ? CW'(DEPTH) : CW'(capacity);
      full = count_ff >= eff_cap;
      first_hit = hit_ff & ~(hit_ff - 1'b1);
      any_hit = |hit_ff;
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) if (first_hit[i]) hit_idx = SW'(i);
      // sorted slot: one past last le entry before the hit
      ins_pos = '0;
      for (int i = 0; i < DEPTH; i++)
         if (live_ff[i] && le_ff[i] && !(any_hit && SW'(i) >= hit_idx))
            ins_pos = CW'(i + 1);
      cut = count_ff;
      for (int i = DEPTH-1; i >= 0; i--)
         if (live_ff[i] && exp_ff[i]) cut = CW'(i);
   end

   // result fields of the request
   always_comb begin
      status_in = ST_DONE;
      pos_in = '0;
      fage_in = '0;
      fmeta_in = '0;
      case (op_ff)
         OP_INSERT: begin
            if (full) status_in = ST_FULL;
            else if (any_hit && !(age_ff[hit_idx] > rage_ff)) status_in = ST_PRESENT;
            else pos_in = CNT_BITS'(ins_pos);
         end
         OP_ADD: begin
            if (any_hit) status_in = ST_PRESENT;
            else if (full) status_in = ST_FULL;
         end
         OP_DELETE: begin
            if (!any_hit) status_in = ST_MISSING;
         end
         OP_LOOKUP: begin
            if (!any_hit) status_in = ST_MISSING;
            else begin
               pos_in = CNT_BITS'(hit_idx);
               fage_in = age_ff[hit_idx];
               fmeta_in = meta_ff[hit_idx];
            end
         end
         default: ;
      endcase
   end

   // stage two: shift cells
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         status_ff <= status_in; pos_ff <= pos_in; fage_ff <= fage_in;
         fmeta_ff <= fmeta_in;
         case (op_ff)
            OP_INSERT: begin
               if (status_in == ST_DONE) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CW'(i) == ins_pos) begin
                        key_ff[i] <= rkey_ff; age_ff[i] <= rage_ff; meta_ff[i] <= rmeta_ff;
                     end else if (i > 0 && CW'(i) > ins_pos &&
                                  (any_hit ? SW'(i) <= hit_idx : CW'(i) <= count_ff)) begin
                        key_ff[i] <= key_ff[i-1]; age_ff[i] <= age_ff[i-1];
                        meta_ff[i] <= meta_ff[i-1];
                     end
                  end
                  if (!any_hit) count_ff <= count_ff + 1'b1;
               end
            end
            OP_ADD: begin
               if (any_hit) begin
                  meta_ff[hit_idx] <= rmeta_ff;
               end else if (!full) begin
                  key_ff[0] <= rkey_ff; age_ff[0] <= AGE_BITS'(1); meta_ff[0] <= rmeta_ff;
                  for (int i = 1; i < DEPTH; i++) begin
                     key_ff[i] <= key_ff[i-1]; age_ff[i] <= age_ff[i-1];
                     meta_ff[i] <= meta_ff[i-1];
                  end
                  count_ff <= count_ff + 1'b1;
               end
            end
            OP_DELETE: begin
               if (any_hit) begin
                  for (int i = 0; i < DEPTH-1; i++)
                     if (SW'(i) >= hit_idx) begin
                        key_ff[i] <= key_ff[i+1]; age_ff[i] <= age_ff[i+1];
                        meta_ff[i] <= meta_ff[i+1];
                     end
                  count_ff <= count_ff - 1'b1;
               end
            end
            OP_AGE: begin
               for (int i = 0; i < DEPTH; i++)
                  if (CW'(i) < cut)
                     age_ff[i] <= ({1'b0, age_ff[i]} + (AGE_BITS+1)'(rstep_ff) >
                                   {1'b0, {AGE_BITS{1'b1}}}) ? '1 :
                                  age_ff[i] + AGE_BITS'(rstep_ff);
               count_ff <= cut;
            end
            default: ;
         endcase
      end
   end

   assign status = status_ff;
   assign position = pos_ff;
   assign entry_count = CNT_BITS'(count_ff);
   assign found_age = fage_ff;
   assign found_meta = fmeta_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count overflow");
   a_full_keep: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && status_in == ST_FULL |=> $stable(count_ff))
      else $error("full table changed count");
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> $onehot0(hit_ff)) else $error("duplicate key");
endmodule

[design/age_ordered_peer_table.sv]
// age_ordered_peer_table: top level of the age ordered peer table
// uses aopt_pkg, aopt_req_if, aopt_ctrl, aopt_dp
//
// channel  dir  handshake        payload
// req      in   valid/ready      op node_key entry_age meta_in age_step
// rsp      out  valid/ready      status position entry_count found_age found_meta
// csr      in   write enable     index, 32-bit data
//
// each request goes through capture with per-slot compare, one shift
// step across all slots, then the result beat; the controller state sets it.
// reset empties the table at once; no clearing pass.
// a stalled result holds the block; no new request is taken until it leaves.
module age_ordered_peer_table #(
   parameter int DEPTH     = 32,
   parameter int KEY_BITS  = 48,
   parameter int META_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   aopt_req_if.sink   req,
   aopt_rsp_if.source rsp,
   input  logic                          csr_we,
   input  logic [aopt_pkg::IDX_BITS-1:0] csr_index,
   input  logic [aopt_pkg::CFG_BITS-1:0] csr_wdata
);
   import aopt_pkg::*;

   cmd_type cmd;
   logic [CNT_BITS-1:0] capacity_ff;
   logic [AGE_BITS-1:0] age_limit_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CNT_BITS'(32);
         age_limit_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_CAPACITY:  capacity_ff <= csr_wdata[CNT_BITS-1:0];
            REG_AGE_LIMIT: age_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   aopt_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd(cmd)
   );

   aopt_dp #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .META_BITS(META_BITS)) u_dp (
      .clock, .reset, .cmd(cmd), .op(req.op), .node_key(req.node_key),
      .entry_age(req.entry_age), .meta_in(req.meta_in), .age_step(req.age_step),
      .capacity(capacity_ff), .age_limit(age_limit_ff),
      .status(rsp.status), .position(rsp.position), .entry_count(rsp.entry_count),
      .found_age(rsp.found_age), .found_meta(rsp.found_meta)
   );
endmodule
